// ----- hdl/rpf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_pkg: shared types, constants and functions of the radio packet framer
// Holds the framing constants, the whitening table, the crc-16 step
// functions and the command word passed from the front end to the back end.
// ----------------------------------------------------------------------------
package rpf_pkg;

    // framing constants
    localparam int unsigned MAX_PAYLOAD_DEF   = 15;
    localparam int unsigned MAX_ADDRESS_BYTES = 5;
    localparam int unsigned MIN_ADDRESS_BYTES = 3;
    localparam int unsigned ADDR_W            = 8 * MAX_ADDRESS_BYTES;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_SEED = 16'hFFFF;
    localparam logic [7:0]  PREAMBLE_ONE  = 8'hAA;
    localparam logic [7:0]  PREAMBLE_ZERO = 8'h55;

    // command queue between front and back end
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_CRC_EN   = 2'd0,
        REG_TX_ADDR  = 2'd1,
        REG_ADDR_LEN = 2'd2
    } t_reg_idx;

    // one command word: header request and/or one payload byte
    typedef struct packed {
        logic       first;     // packet opens with this word: send header
        logic [3:0] len;       // sampled payload length for the control byte
        logic [1:0] pid;       // packet id for the control byte
        logic       has_pay;   // a payload byte follows the header
        logic [7:0] pay_byte;  // whitened, shifted byte as sent
        logic       fin;       // packet ends after this word
        logic       trail;     // carried bit placed in the trailing byte
    } t_cmd;

    // live configuration seen by the back end
    typedef struct packed {
        logic              crc_en;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        alen;
    } t_cfg;

    // queue status toward the producer and the consumer
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_st;

    // whitening table
    function automatic logic [7:0] whiten_byte(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0:    v = 8'h80;
            4'd1:    v = 8'hf5;
            4'd2:    v = 8'h3b;
            4'd3:    v = 8'h0d;
            4'd4:    v = 8'h6d;
            4'd5:    v = 8'h2a;
            4'd6:    v = 8'hf9;
            4'd7:    v = 8'hbc;
            4'd8:    v = 8'h51;
            4'd9:    v = 8'h8e;
            4'd10:   v = 8'h4c;
            4'd11:   v = 8'hfd;
            4'd12:   v = 8'hc1;
            4'd13:   v = 8'h65;
            4'd14:   v = 8'hd0;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // single crc-16-ccitt shift step
    function automatic logic [15:0] crc_step(input logic [15:0] c);
        return c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    endfunction

    // feed a whole byte, msb first
    function automatic logic [15:0] crc_feed8(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            x = crc_step(x);
        end
        return x;
    endfunction

    // feed one bit (the trailing carried bit)
    function automatic logic [15:0] crc_feed1(input logic [15:0] c, input logic bit_in);
        return crc_step(c ^ {bit_in, 15'h0000});
    endfunction

    // address byte k of the transmit address
    function automatic logic [7:0] addr_byte(input logic [ADDR_W-1:0] a, input logic [2:0] k);
        return a[{k, 3'b000} +: 8];
    endfunction

endpackage

// ----- hdl/rpf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_front: input word classifier
// Tracks packet boundaries, packet id, payload index and the carried bit,
// whitens each payload byte and pushes one command word per input word.
// ----------------------------------------------------------------------------
module rpf_front #(
    parameter int unsigned MAX_PAYLOAD = rpf_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [7:0]          i_data_byte,
    input  logic [3:0]          i_payload_length,
    input  logic                i_last_item,
    output logic                o_in_stall,
    input  rpf_pkg::t_q_st      i_q_st,
    output logic                o_push,
    output rpf_pkg::t_cmd       o_cmd
);
    import rpf_pkg::*;

    logic       r_in_packet, n_in_packet;
    logic [1:0] r_pid, n_pid;
    logic       r_carry, n_carry;
    logic [3:0] r_idx, n_idx;

    logic       w_carry;
    logic [3:0] w_idx;
    logic [7:0] w_white;
    logic [4:0] w_idx_inc;
    logic       w_fin_pay;

    // stall only when the command queue is full
    assign o_in_stall = i_q_st.full;
    assign o_push     = i_in_valid && !i_q_st.full;

    // whiten and shift the current byte
    assign w_carry   = r_in_packet ? r_carry : 1'b1;
    assign w_idx     = r_in_packet ? r_idx : 4'd0;
    assign w_white   = i_data_byte ^ whiten_byte(w_idx);
    assign w_idx_inc = {1'b0, w_idx} + 5'd1;
    assign w_fin_pay = i_last_item || (w_idx_inc >= 5'(MAX_PAYLOAD));

    // build the command word and next packet state
    always_comb begin
        n_in_packet = r_in_packet;
        n_pid       = r_pid;
        n_carry     = r_carry;
        n_idx       = r_idx;

        o_cmd.first    = !r_in_packet;
        o_cmd.len      = i_payload_length;
        o_cmd.pid      = r_pid;
        o_cmd.has_pay  = 1'b1;
        o_cmd.pay_byte = {w_carry, w_white[7:1]};
        o_cmd.fin      = w_fin_pay;
        o_cmd.trail    = w_white[0];

        if (!r_in_packet) begin
            n_pid = r_pid + 2'd1;
        end

        if (!r_in_packet && i_payload_length == 4'd0) begin
            // empty packet: header then trailer only
            o_cmd.has_pay = 1'b0;
            o_cmd.fin     = 1'b1;
            o_cmd.trail   = 1'b1;
            n_in_packet   = 1'b0;
            n_carry       = 1'b0;
            n_idx         = 4'd0;
        end else if (w_fin_pay) begin
            n_in_packet = 1'b0;
            n_carry     = 1'b0;
            n_idx       = 4'd0;
        end else begin
            n_in_packet = 1'b1;
            n_carry     = w_white[0];
            n_idx       = w_idx_inc[3:0];
        end
    end

    // packet state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
            r_pid       <= 2'd0;
            r_carry     <= 1'b0;
            r_idx       <= 4'd0;
        end else if (o_push) begin
            r_in_packet <= n_in_packet;
            r_pid       <= n_pid;
            r_carry     <= n_carry;
            r_idx       <= n_idx;
        end
    end

endmodule

// ----- hdl/rpf_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_queue: command queue
// Small register fifo that decouples the classifier from the byte emitter.
// ----------------------------------------------------------------------------
module rpf_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rpf_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output rpf_pkg::t_cmd      o_cmd,
    output rpf_pkg::t_q_st     o_st
);
    import rpf_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_cmd      = r_mem[r_rd];
    assign o_st.empty = (r_cnt == '0);
    assign o_st.full  = (r_cnt == (QPTR_W+1)'(QDEPTH));

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- hdl/rpf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_back: frame byte emitter
// Walks each command word through header, payload and trailer states, runs
// the crc-16 and, unless stalled, drives one byte per cycle to the output.
// ----------------------------------------------------------------------------
module rpf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rpf_pkg::t_cfg      i_cfg,
    input  rpf_pkg::t_cmd      i_cmd,
    input  logic               i_cmd_avail,
    output logic               o_pop,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_last_byte
);
    import rpf_pkg::*;

    typedef enum logic [9:0] {
        S_HEAD   = 10'b00_0000_0001,
        S_ADDR   = 10'b00_0000_0010,
        S_GUARD0 = 10'b00_0000_0100,
        S_GUARD1 = 10'b00_0000_1000,
        S_CTRL   = 10'b00_0001_0000,
        S_PAY    = 10'b00_0010_0000,
        S_TR0    = 10'b00_0100_0000,
        S_TR1    = 10'b00_1000_0000,
        S_TR2    = 10'b01_0000_0000,
        S_SPARE  = 10'b10_0000_0000
    } t_state;

    t_state      r_state, n_state;
    logic [2:0]  r_cnt, n_cnt;
    logic [15:0] r_crc, n_crc;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_last;

    logic        w_adv, w_step, w_pop, w_last;
    logic [7:0]  w_byte;
    logic [2:0]  w_alen;
    logic [15:0] w_crc1;
    logic [7:0]  w_ctrl;
    logic [7:0]  w_top_addr;

    // address length clamped to the supported range
    always_comb begin
        if (i_cfg.alen < 3'(MIN_ADDRESS_BYTES)) begin
            w_alen = 3'(MIN_ADDRESS_BYTES);
        end else if (i_cfg.alen > 3'(MAX_ADDRESS_BYTES)) begin
            w_alen = 3'(MAX_ADDRESS_BYTES);
        end else begin
            w_alen = i_cfg.alen;
        end
    end

    // highest address byte in use selects the preamble
    assign w_top_addr = addr_byte(i_cfg.addr, w_alen - 3'd1);

    assign w_ctrl = {2'b00, i_cmd.len, i_cmd.pid};
    assign w_crc1 = crc_feed1(r_crc, i_cmd.trail);

    // output register free or being drained
    assign w_adv  = !r_out_valid || !i_out_stall;
    assign w_step = w_adv && (r_state != S_HEAD || i_cmd_avail);
    assign o_pop  = w_step && w_pop;

    // byte sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_crc   = r_crc;
        w_byte  = 8'h00;
        w_last  = 1'b0;
        w_pop   = 1'b0;
        unique case (r_state) inside
            S_HEAD, S_PAY: begin
                if (r_state == S_HEAD && i_cmd.first) begin
                    w_byte  = w_top_addr[7] ? PREAMBLE_ONE : PREAMBLE_ZERO;
                    n_crc   = CRC_SEED;
                    n_cnt   = w_alen - 3'd1;
                    n_state = S_ADDR;
                end else begin
                    w_byte = i_cmd.pay_byte;
                    n_crc  = crc_feed8(r_crc, i_cmd.pay_byte);
                    if (i_cmd.fin) begin
                        n_state = S_TR0;
                    end else begin
                        w_pop   = 1'b1;
                        n_state = S_HEAD;
                    end
                end
            end
            S_ADDR: begin
                w_byte = addr_byte(i_cfg.addr, r_cnt);
                n_crc  = crc_feed8(r_crc, w_byte);
                if (r_cnt == 3'd0) begin
                    n_state = S_GUARD0;
                end else begin
                    n_cnt = r_cnt - 3'd1;
                end
            end
            S_GUARD0: begin
                w_byte  = addr_byte(i_cfg.addr, 3'd0);
                n_state = S_GUARD1;
            end
            S_GUARD1: begin
                w_byte  = addr_byte(i_cfg.addr, 3'd0);
                n_state = S_CTRL;
            end
            S_CTRL: begin
                w_byte  = w_ctrl;
                n_crc   = crc_feed8(r_crc, w_ctrl);
                n_state = i_cmd.has_pay ? S_PAY : S_TR0;
            end
            S_TR0: begin
                if (i_cfg.crc_en) begin
                    w_byte  = {i_cmd.trail, w_crc1[15:9]};
                    n_crc   = w_crc1;
                    n_state = S_TR1;
                end else begin
                    w_byte  = {i_cmd.trail, 7'b000_0000};
                    w_last  = 1'b1;
                    w_pop   = 1'b1;
                    n_state = S_HEAD;
                end
            end
            S_TR1: begin
                w_byte  = r_crc[8:1];
                n_state = S_TR2;
            end
            S_TR2: begin
                w_byte  = {r_crc[0], 7'b000_0000};
                w_last  = 1'b1;
                w_pop   = 1'b1;
                n_state = S_HEAD;
            end
            default: begin
                n_state = S_HEAD;
            end
        endcase
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HEAD;
            r_cnt   <= 3'd0;
            r_crc   <= CRC_SEED;
        end else if (w_step) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_crc   <= n_crc;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_byte <= w_byte;
            r_last     <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_last;

endmodule

// ----- hdl/radio_packet_framer_crc16_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_packet_framer_crc16_core: radio packet framer with crc-16
// Turns payload words into the framed over-the-air byte stream with
// preamble, address, guard bytes, control field, whitened payload and crc.
// ----------------------------------------------------------------------------
// The block emits one framed byte per clock while the output is not stalled.
// The first word of a packet produces address_length + 5 bytes (preamble,
// address, two guard bytes, control byte, first payload byte), each further
// payload word one byte, and the final word one more byte without crc or
// three more with crc; an empty packet yields header plus trailer. The byte
// emitter sets the rate; a four-entry command queue lets input words enter at
// one per cycle while the header is still being sent, until the queue is full.
// Configuration is written over the apb port at byte addresses 0, 8 and 16
// while idle; the user must keep to this, as the block does not enforce it.
// ----------------------------------------------------------------------------
module radio_packet_framer_crc16_core #(
    parameter int unsigned MAX_PAYLOAD = rpf_pkg::MAX_PAYLOAD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic [3:0]  i_payload_length,
    input  logic        i_last_item,
    // output words
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import rpf_pkg::*;

    logic              r_crc_en;
    logic [ADDR_W-1:0] r_tx_addr;
    logic [2:0]        r_addr_len;

    logic     w_wr;
    t_reg_idx w_reg;
    t_cfg     w_cfg;
    t_cmd     w_push_cmd, w_head_cmd;
    t_q_st    w_q_st;
    logic     w_push, w_pop;

    // configuration registers
    assign pready = 1'b1;
    assign w_reg  = t_reg_idx'(paddr[4:3]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_en   <= 1'b1;
            r_tx_addr  <= '0;
            r_addr_len <= 3'(MAX_ADDRESS_BYTES);
        end else if (w_wr) begin
            unique case (w_reg)
                REG_CRC_EN:   r_crc_en   <= pwdata[0];
                REG_TX_ADDR:  r_tx_addr  <= pwdata[ADDR_W-1:0];
                REG_ADDR_LEN: r_addr_len <= pwdata[2:0];
                default:      ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (w_reg)
            REG_CRC_EN:   prdata = {63'd0, r_crc_en};
            REG_TX_ADDR:  prdata = {{(64-ADDR_W){1'b0}}, r_tx_addr};
            REG_ADDR_LEN: prdata = {61'd0, r_addr_len};
            default:      prdata = 64'd0;
        endcase
    end

    assign w_cfg.crc_en = r_crc_en;
    assign w_cfg.addr   = r_tx_addr;
    assign w_cfg.alen   = r_addr_len;

    // classifier
    rpf_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_data_byte      (i_data_byte),
        .i_payload_length (i_payload_length),
        .i_last_item      (i_last_item),
        .o_in_stall       (o_in_stall),
        .i_q_st           (w_q_st),
        .o_push           (w_push),
        .o_cmd            (w_push_cmd)
    );

    // command queue
    rpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_st    (w_q_st)
    );

    // byte emitter
    rpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_head_cmd),
        .i_cmd_avail (!w_q_st.empty),
        .o_pop       (w_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

    // back end never retires a word the queue does not hold
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_st.empty)
        else $error("queue popped while empty");

    // front end never writes into a full queue
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_st.full)
        else $error("queue pushed while full");

    // retiring a word always leaves a byte in the output register
    a_pop_outputs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_out_valid)
        else $error("word retired without an output byte");

endmodule
